// ----- design/hpr_pkg.sv -----
// Shared types, constants and register codes for the hit to pixel ROI mapper.
package hpr_pkg;

  // Default ROI table size and the largest table the 4-bit index can address.
  localparam int NUM_ROI_DEF = 16;
  localparam int TABLE_MAX   = 16;

  // ROI box geometry and the pixel channel bank split.
  localparam int ROI_H    = 8;
  localparam int ROI_W    = 15;
  localparam int PIX_BANK = 120;

  // Rounding constants for the Q.16 to pixel conversion.
  localparam logic [33:0] HALF_POS = 34'd32768;
  localparam logic [33:0] HALF_NEG = 34'd32769;

  // Saturation bounds of the time sample.
  localparam logic [23:0] T_MAX = 24'h7F_FFFF;
  localparam logic [23:0] T_MIN = 24'h80_0000;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_Z,
    REG_ORIGIN_Y,
    REG_INV_PITCH,
    REG_WIDTH_LIMIT,
    REG_HEIGHT_LIMIT,
    REG_TIME_SCALE
  } cfg_reg_t;

  // Configuration reset values.
  localparam logic [15:0] ORIGIN_Z_RST     = 16'd0;
  localparam logic [15:0] ORIGIN_Y_RST     = 16'd0;
  localparam logic [15:0] INV_PITCH_RST    = 16'd160;
  localparam logic [15:0] WIDTH_LIMIT_RST  = 16'd7776;
  localparam logic [15:0] HEIGHT_LIMIT_RST = 16'd4000;
  localparam logic [15:0] TIME_SCALE_RST   = 16'd256;

  typedef struct packed {
    logic [15:0] origin_z;
    logic [15:0] origin_y;
    logic [15:0] inv_pitch;
    logic [15:0] width_limit;
    logic [15:0] height_limit;
    logic [15:0] time_scale;
  } cfg_t;

  // Payload of a table load item as it travels down the pipeline.
  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] top;
    logic [7:0] left;
  } roi_ld_t;

  // Stage 1: offsets from the board origin and the raw time product.
  typedef struct packed {
    logic               valid;
    logic               load;
    roi_ld_t            ld;
    logic signed [16:0] dy;
    logic signed [16:0] dz;
    logic signed [32:0] tprod;
  } s1_t;

  // Stage 2: Q.16 pixel products and the saturated time sample.
  typedef struct packed {
    logic               valid;
    logic               load;
    roi_ld_t            ld;
    logic signed [33:0] py_p;
    logic signed [33:0] pz_p;
    logic [23:0]        t;
  } s2_t;

  // Stage 3: rounded pixel coordinates in sign and magnitude form.
  typedef struct packed {
    logic        valid;
    logic        load;
    roi_ld_t     ld;
    logic        ny;
    logic [16:0] qy;
    logic        nz;
    logic [16:0] qz;
    logic [23:0] t;
  } s3_t;

  // Result register.
  typedef struct packed {
    logic        valid;
    logic        visible;
    logic [23:0] t;
    logic [3:0]  ch;
    logic        found;
    logic [7:0]  pix;
  } res_t;

endpackage

// ----- design/hpr_scale.sv -----
// Origin subtraction, pitch and time multiplies, and time saturation (stages 1 and 2).
module hpr_scale import hpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic               req_type,
  input  logic signed [15:0] hit_x,
  input  logic signed [15:0] hit_y,
  input  logic signed [15:0] hit_z,
  input  logic [3:0]         roi_index,
  input  logic signed [7:0]  roi_top_y,
  input  logic [7:0]         roi_left_z,
  input  cfg_t               cfg,
  output s2_t                s2
);

  s1_t s1;
  s1_t s1_next;
  s2_t s2_next;

  // Stage 1: offsets relative to the board origin and the drift time product.
  always_comb begin
    s1_next.valid   = in_valid;
    s1_next.load    = req_type;
    s1_next.ld.idx  = roi_index;
    s1_next.ld.top  = roi_top_y;
    s1_next.ld.left = roi_left_z;
    s1_next.dy      = $signed({hit_y[15], hit_y}) -
                      $signed({cfg.origin_y[15], cfg.origin_y});
    s1_next.dz      = $signed({hit_z[15], hit_z}) -
                      $signed({cfg.origin_z[15], cfg.origin_z});
    s1_next.tprod   = hit_x * $signed({1'b0, cfg.time_scale});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;
    end
  end

  // Stage 2: scale by the reciprocal pitch and clamp the time sample.
  always_comb begin
    s2_next.valid = s1.valid;
    s2_next.load  = s1.load;
    s2_next.ld    = s1.ld;
    s2_next.py_p  = $signed(s1.dy) * $signed({1'b0, cfg.inv_pitch});
    s2_next.pz_p  = $signed(s1.dz) * $signed({1'b0, cfg.inv_pitch});
    if (s1.tprod[32:23] == {10{s1.tprod[32]}}) begin
      s2_next.t = s1.tprod[23:0];
    end else if (s1.tprod[32]) begin
      s2_next.t = T_MIN;
    end else begin
      s2_next.t = T_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2 <= s2_next;
    end
  end

endmodule

// ----- design/hpr_round.sv -----
// Rounding of the Q.16 products to whole pixels, half away from zero (stage 3).
module hpr_round import hpr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  s2_t  s2,
  output s3_t  s3
);

  s3_t s3_next;

  // The magnitude plus one half is formed in one add: for a negative value,
  // ~p equals |p| - 1, so the rounding constant grows by one.
  function automatic logic [17:0] round_mag(input logic [33:0] p);
    logic        neg;
    logic [33:0] sum;
    neg = p[33];
    sum = (neg ? ~p : p) + (neg ? HALF_NEG : HALF_POS);
    return {neg, sum[32:16]};
  endfunction

  always_comb begin
    s3_next.valid        = s2.valid;
    s3_next.load         = s2.load;
    s3_next.ld           = s2.ld;
    {s3_next.ny, s3_next.qy} = round_mag(s2.py_p);
    {s3_next.nz, s3_next.qz} = round_mag(s2.pz_p);
    s3_next.t            = s2.t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else if (en) begin
      s3 <= s3_next;
    end
  end

endmodule

// ----- design/hpr_roi.sv -----
// ROI table, visibility check, box match and pixel channel (stages 4 and 5).
module hpr_roi import hpr_pkg::*; #(
  parameter int NUM_ROI = NUM_ROI_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  s3_t  s3,
  input  cfg_t cfg,
  output res_t res
);

  localparam int TABLE_DEPTH = (NUM_ROI < TABLE_MAX) ? NUM_ROI : TABLE_MAX;

  logic [15:0] roi_table [TABLE_DEPTH];

  logic                   s4_valid;
  logic                   s4_vis;
  logic [TABLE_DEPTH-1:0] s4_match;
  logic [2:0]             s4_m8;
  logic [5:0]             s4_a15;
  logic                   s4_bank;
  logic [23:0]            s4_t;

  logic                   vis_next;
  logic [TABLE_DEPTH-1:0] match_next;
  logic [5:0]             a15_next;
  res_t                   res_next;
  logic [4:0]             fold;
  logic [3:0]             m15;

  // A load item writes its entry as it passes this stage, so map items
  // before it and after it see the table in transfer order.
  always_ff @(posedge clk) begin
    if (en && s3.valid && s3.load) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (s3.ld.idx == 4'(i)) begin
          roi_table[i] <= {s3.ld.top, s3.ld.left};
        end
      end
    end
  end

  // Stage 4: board limits, per-entry box tests and the mod 15 nibble sum.
  // A visible hit has py = -qy and pz = qz.
  always_comb begin
    logic signed [18:0] sy;
    logic signed [18:0] sz;
    vis_next = (s3.ny || (s3.qy == 17'd0)) &&
               (!s3.nz || (s3.qz == 17'd0)) &&
               ({s3.qy, 6'b0} <= {7'b0, cfg.height_limit}) &&
               ({s3.qz, 6'b0} <= {7'b0, cfg.width_limit});
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sy = $signed({2'b00, s3.qy}) +
           $signed({{11{roi_table[i][15]}}, roi_table[i][15:8]});
      sz = $signed({2'b00, s3.qz}) - $signed({11'b0, roi_table[i][7:0]});
      match_next[i] = (sy >= 19'sd0) && (sy < 19'(ROI_H)) &&
                      (sz >= 19'sd0) && (sz < 19'(ROI_W));
    end
    // A visible z stays below 1024, so three nibbles cover it.
    a15_next = 6'(s3.qz[3:0]) + 6'(s3.qz[7:4]) + 6'(s3.qz[9:8]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3.valid && !s3.load;
      s4_vis   <= vis_next;
      s4_match <= match_next;
      s4_m8    <= s3.qy[2:0];
      s4_a15   <= a15_next;
      s4_bank  <= (s3.qz >= 17'(PIX_BANK));
      s4_t     <= s3.t;
    end
  end

  // Stage 5: first matching entry, final mod 15 fold and channel number.
  always_comb begin
    fold = 5'(s4_a15[3:0]) + 5'(s4_a15[5:4]);
    m15  = (fold >= 5'(ROI_W)) ? 4'(fold - 5'(ROI_W)) : fold[3:0];

    res_next.valid   = s4_valid;
    res_next.visible = s4_vis;
    res_next.t       = s4_t;
    res_next.found   = s4_vis && (|s4_match);
    res_next.ch      = 4'd0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (s4_match[i]) begin
        res_next.ch = 4'(i);
      end
    end
    if (!s4_vis) begin
      res_next.ch = 4'd0;
    end
    res_next.pix = {1'b0, s4_m8, 4'b0} - 8'(s4_m8) + 8'(m15) +
                   (s4_bank ? 8'(PIX_BANK) : 8'd0);
    if (!s4_vis) begin
      res_next.pix = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res <= res_next;
    end
  end

endmodule

// ----- design/hit_to_pixel_roi_mapper_core.sv -----
// Top level of the hit to pixel ROI mapper: configuration, pipeline control and ports.
//
// The mapper takes one item per clock cycle while no result waits on out_ready
// and returns the result of a map item after its five register stages: origin
// subtraction with the time multiply, the pitch multiplies with time saturation,
// rounding to pixels, the limit and ROI box tests, and the final priority select
// that feeds the output register. Table load items pass through the same stages,
// write their entry at the box test stage and give no result. A result that waits
// on out_ready holds the whole pipeline, and in_ready drops for as long as it waits.
// The ROI table needs no clearing after reset, but every entry a search covers must
// be loaded before the first hit is mapped. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
module hit_to_pixel_roi_mapper_core import hpr_pkg::*; #(
  parameter int NUM_ROI = NUM_ROI_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic signed [15:0]   hit_x,
  input  logic signed [15:0]   hit_y,
  input  logic signed [15:0]   hit_z,
  input  logic [3:0]           roi_index,
  input  logic signed [7:0]    roi_top_y,
  input  logic [7:0]           roi_left_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 visible,
  output logic signed [23:0]   time_sample,
  output logic [3:0]           roi_channel,
  output logic                 roi_found,
  output logic [7:0]           pixel_channel,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t cfg;
  s2_t  s2;
  s3_t  s3;
  res_t res;
  logic en;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_z     <= ORIGIN_Z_RST;
      cfg.origin_y     <= ORIGIN_Y_RST;
      cfg.inv_pitch    <= INV_PITCH_RST;
      cfg.width_limit  <= WIDTH_LIMIT_RST;
      cfg.height_limit <= HEIGHT_LIMIT_RST;
      cfg.time_scale   <= TIME_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_Z:     cfg.origin_z     <= cfg_data;
        REG_ORIGIN_Y:     cfg.origin_y     <= cfg_data;
        REG_INV_PITCH:    cfg.inv_pitch    <= cfg_data;
        REG_WIDTH_LIMIT:  cfg.width_limit  <= cfg_data;
        REG_HEIGHT_LIMIT: cfg.height_limit <= cfg_data;
        REG_TIME_SCALE:   cfg.time_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output register is empty or drained.
  assign en       = !res.valid || out_ready;
  assign in_ready = en;

  hpr_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .req_type   (req_type),
    .hit_x      (hit_x),
    .hit_y      (hit_y),
    .hit_z      (hit_z),
    .roi_index  (roi_index),
    .roi_top_y  (roi_top_y),
    .roi_left_z (roi_left_z),
    .cfg        (cfg),
    .s2         (s2)
  );

  hpr_round u_round (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .s2  (s2),
    .s3  (s3)
  );

  hpr_roi #(
    .NUM_ROI (NUM_ROI)
  ) u_roi (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .s3  (s3),
    .cfg (cfg),
    .res (res)
  );

  // Result ports.
  assign out_valid     = res.valid;
  assign visible       = res.visible;
  assign time_sample   = res.t;
  assign roi_channel   = res.ch;
  assign roi_found     = res.found;
  assign pixel_channel = res.pix;

  // A found box implies the hit is on the board.
  a_found_visible: assert property (@(posedge clk) disable iff (rst)
    out_valid && roi_found |-> visible)
    else $error("ROI match reported for a hit off the board");

  // An off-board hit carries no ROI or pixel channel.
  a_offboard_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> !roi_found && (roi_channel == 4'd0) &&
                              (pixel_channel == 8'd0))
    else $error("Off-board hit carries channel data");

  // A waiting result freezes the inner stages as well.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(s2.valid) && $stable(s3.valid))
    else $error("Pipeline moved while the result was stalled");

endmodule
